FILE: rtl/core/sos_pkg.sv
// sos_pkg: shared widths, codes and types for the set-of-stacks block
// no dependencies; imported by set_of_stacks_with_pop_at, sos_front and sos_engine
`timescale 1ns / 1ps

package sos_pkg;

    localparam int DEFAULT_STORE_DEPTH = 256;

    localparam int VAL_W     = 32;
    localparam int CAP_W     = 9;
    localparam int IDX_W     = 8;
    localparam int ACT_W     = 2;
    localparam int CNT_OUT_W = 9;
    localparam int PROD_W    = IDX_W + 1 + CAP_W;

    localparam int S_DATA_W = ((VAL_W + IDX_W) + 7) / 8 * 8;
    localparam int S_PAD_W  = S_DATA_W - VAL_W - IDX_W;
    localparam int M_DATA_W = ((VAL_W + 2 * CNT_OUT_W) + 7) / 8 * 8;
    localparam int M_PAD_W  = M_DATA_W - VAL_W - 2 * CNT_OUT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);

    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP_AT = 2'd2;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_POP_AT,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2,
        STS_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_POP_DATA,
        ENG_AT_POS,
        ENG_AT_DATA,
        ENG_SHIFT,
        ENG_DIV
    } eng_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  idx;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0]     popped;
        status_t              status;
        logic [CNT_OUT_W-1:0] item_count;
        logic [CNT_OUT_W-1:0] substack_count;
    } res_t;

endpackage

FILE: rtl/core/set_of_stacks_with_pop_at.sv
// set_of_stacks_with_pop_at: stack split into substacks of configurable capacity
// depends on sos_pkg, sos_front, sos_engine (and sos_ram below it)
// usage:
//   s_ channel carries commands: s_tuser is the action (push, pop, pop at a
//   substack, anything else is a no-op), s_tdata the push value and index.
//   m_ channel returns one transaction per command: popped value, counts and
//   the status code in m_tuser.
//   cfg channel writes the substack capacity (0 acts as 1); write it only
//   while no command is outstanding.
// a command passes the two-entry queue, then the engine: push, no-op and
//   any error answer from ENG_IDLE; pop reads the store in ENG_POP_DATA;
//   pop at a substack: ENG_AT_POS, ENG_AT_DATA, ENG_SHIFT while entries move down.
// throughput is set by the registered-read store in the engine: one push per
//   cycle while m_ takes results; after a pop of either kind the next command
//   waits for its result. a capacity write to a non-empty stack recounts the
//   substacks bit by bit; commands wait in the queue meanwhile.
// reset empties the stack and sets the capacity to 3; store contents are
//   left as they are and never read before being written.
// a stalled m_ side holds its result; a two-entry command queue keeps
//   accepting on the s_ side until it fills.
`timescale 1ns / 1ps

module set_of_stacks_with_pop_at #(
    parameter int STORE_DEPTH = sos_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // push_value[31:0], substack_index[39:32]
    input  logic [sos_pkg::S_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [sos_pkg::ACT_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // popped_value[31:0], item_count[40:32], substack_count[49:41], zero fill
    output logic [sos_pkg::M_DATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sos_pkg::CAP_W-1:0]      cfg_data
);
    import sos_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    res_t res;

    sos_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .action         (s_tuser),
        .push_value     (s_tdata[VAL_W-1:0]),
        .substack_index (s_tdata[VAL_W+IDX_W-1:VAL_W]),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    sos_engine #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, res.substack_count, res.item_count, res.popped};
    assign m_tuser = res.status;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res.item_count == '0) == (res.substack_count == '0)))
        else $error("substack count disagrees with item count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STS_FULL) |-> (res.item_count == CNT_OUT_W'(STORE_DEPTH)))
        else $error("full status with store not full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STS_RANGE) |-> (res.item_count != '0))
        else $error("index error reported on empty store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("command queue filled without a transaction");

endmodule

FILE: rtl/core/sos_ram.sv
// sos_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sos_front.sv
// sos_front: accepts input transactions, decodes the action and queues commands
// depends on sos_pkg
`timescale 1ns / 1ps

module sos_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sos_pkg::ACT_W-1:0]     action,
    input  logic [sos_pkg::VAL_W-1:0]     push_value,
    input  logic [sos_pkg::IDX_W-1:0]     substack_index,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output sos_pkg::cmd_t                 cmd
);
    import sos_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       decoded;
    logic       push_en;
    logic       pop_en;

    always_comb begin
        decoded.value = push_value;
        decoded.idx   = substack_index;
        unique case (action)
            ACT_PUSH:   decoded.kind = CMD_PUSH;
            ACT_POP:    decoded.kind = CMD_POP;
            ACT_POP_AT: decoded.kind = CMD_POP_AT;
            default:    decoded.kind = CMD_NOP;
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push_en   = s_valid && s_ready;
    assign pop_en    = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_en} - {1'b0, pop_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

FILE: rtl/core/sos_engine.sv
// sos_engine: executes queued commands on the flat store and keeps the counters
// depends on sos_pkg and sos_ram
`timescale 1ns / 1ps

module sos_engine #(
    parameter int STORE_DEPTH = sos_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  sos_pkg::cmd_t             cmd,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [sos_pkg::CAP_W-1:0] cfg_data,
    output logic                      res_valid,
    input  logic                      res_ready,
    output sos_pkg::res_t             res
);
    import sos_pkg::*;

    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CMP_W  = (CNT_W > PROD_W) ? CNT_W : PROD_W;
    localparam int IW     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int DC_W   = $clog2(CNT_W);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STORE_DEPTH);

    eng_state_t        state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  entry_reg, entry_next;
    logic [CNT_W-1:0]  sub_reg, sub_next;
    logic [CAP_W-1:0]  fill_reg, fill_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [VAL_W-1:0]  popped_reg, popped_next;
    logic [CNT_W-1:0]  dvd_reg, dvd_next;
    logic [CAP_W-1:0]  rem_reg, rem_next;
    logic [DC_W-1:0]   dc_reg, dc_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic [CAP_W-1:0]  eff_cap;
    logic [ADDR_W-1:0] top_addr;
    logic              out_free;
    logic              cmd_fire;
    logic              cfg_fire;
    logic              is_empty;
    logic              is_full;
    logic              idx_bad;
    logic [CNT_W-1:0]  inc_sub, dec_sub;
    logic [CAP_W-1:0]  inc_fill, dec_fill;
    logic [CMP_W-1:0]  end_pos;
    logic [CAP_W:0]    trial;
    logic              qbit;
    logic [CAP_W-1:0]  rem_step;
    logic [IDX_W:0]    idx_p1;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    sos_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign eff_cap   = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign top_addr  = ADDR_W'(entry_reg - 1'b1);
    assign out_free  = !out_valid_reg || res_ready;
    assign cfg_ready = (state_reg == ENG_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cmd_ready = (state_reg == ENG_IDLE) && !cfg_valid && out_free;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign is_empty  = (entry_reg == '0);
    assign is_full   = (entry_reg == FULL_CNT);
    assign idx_bad   = (IW'(cmd.idx) >= IW'(sub_reg));
    assign idx_p1    = (IDX_W + 1)'(cmd.idx) + 1'b1;
    assign end_pos   = (CMP_W'(prod_reg) > CMP_W'(entry_reg)) ? CMP_W'(entry_reg)
                                                               : CMP_W'(prod_reg);

    // substack bookkeeping for one entry more or one entry less
    always_comb begin
        if (is_empty || fill_reg == eff_cap) begin
            inc_sub  = sub_reg + 1'b1;
            inc_fill = CAP_W'(1);
        end else begin
            inc_sub  = sub_reg;
            inc_fill = fill_reg + 1'b1;
        end
        if (fill_reg == CAP_W'(1)) begin
            dec_sub  = sub_reg - 1'b1;
            dec_fill = (sub_reg == CNT_W'(1)) ? '0 : eff_cap;
        end else begin
            dec_sub  = sub_reg;
            dec_fill = fill_reg - 1'b1;
        end
    end

    // restoring division step for (entries - 1) / capacity
    always_comb begin
        trial = {rem_reg, dvd_reg[CNT_W-1]};
        qbit  = (trial >= {1'b0, eff_cap});
        rem_step = qbit ? CAP_W'(trial - {1'b0, eff_cap}) : CAP_W'(trial);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                priority if (cfg_fire) begin
                    state_next = (entry_reg != '0) ? ENG_DIV : ENG_IDLE;
                end else if (cmd_fire) begin
                    unique case (cmd.kind)
                        CMD_POP:    state_next = is_empty ? ENG_IDLE : ENG_POP_DATA;
                        CMD_POP_AT: state_next = (is_empty || idx_bad) ? ENG_IDLE
                                                                       : ENG_AT_POS;
                        default:    state_next = ENG_IDLE;
                    endcase
                end else begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_POP_DATA: state_next = ENG_IDLE;
            ENG_AT_POS:   state_next = ENG_AT_DATA;
            ENG_AT_DATA:  state_next = (pos_reg == top_addr) ? ENG_IDLE : ENG_SHIFT;
            ENG_SHIFT:    state_next = (ADDR_W'(wr_ptr_reg + 1'b1) == top_addr) ? ENG_IDLE
                                                                                 : ENG_SHIFT;
            ENG_DIV:      state_next = (dc_reg == '0) ? ENG_IDLE : ENG_DIV;
            default:      state_next = ENG_IDLE;
        endcase
    end

    always_comb begin
        cap_next       = cap_reg;
        entry_next     = entry_reg;
        sub_next       = sub_reg;
        fill_next      = fill_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        wr_ptr_next    = wr_ptr_reg;
        popped_next    = popped_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dc_next        = dc_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(entry_reg);
        ram_wdata      = cmd.value;
        ram_raddr      = top_addr;

        unique case (state_reg)
            ENG_IDLE: begin
                priority if (cfg_fire) begin
                    cap_next = cfg_data;
                    dvd_next = entry_reg - 1'b1;
                    rem_next = '0;
                    dc_next  = DC_W'(CNT_W - 1);
                end else if (cmd_fire) begin
                    out_valid_next          = 1'b1;
                    out_next.popped         = '0;
                    out_next.status         = STS_OK;
                    out_next.item_count     = CNT_OUT_W'(entry_reg);
                    out_next.substack_count = CNT_OUT_W'(sub_reg);
                    unique case (cmd.kind)
                        CMD_PUSH: begin
                            if (is_full) begin
                                out_next.status = STS_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                entry_next = entry_reg + 1'b1;
                                sub_next   = inc_sub;
                                fill_next  = inc_fill;
                                out_next.item_count     = CNT_OUT_W'(entry_reg + 1'b1);
                                out_next.substack_count = CNT_OUT_W'(inc_sub);
                            end
                        end
                        CMD_POP: begin
                            if (is_empty) begin
                                out_next.status = STS_EMPTY;
                            end else begin
                                out_valid_next = 1'b0;
                                entry_next     = entry_reg - 1'b1;
                                sub_next       = dec_sub;
                                fill_next      = dec_fill;
                            end
                        end
                        CMD_POP_AT: begin
                            priority if (is_empty) begin
                                out_next.status = STS_EMPTY;
                            end else if (idx_bad) begin
                                out_next.status = STS_RANGE;
                            end else begin
                                out_valid_next = 1'b0;
                                prod_next      = PROD_W'(idx_p1) * PROD_W'(eff_cap);
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    ram_we = 1'b0;
                end
            end
            ENG_POP_DATA: begin
                out_valid_next          = 1'b1;
                out_next.popped         = ram_rdata;
                out_next.status         = STS_OK;
                out_next.item_count     = CNT_OUT_W'(entry_reg);
                out_next.substack_count = CNT_OUT_W'(sub_reg);
            end
            ENG_AT_POS: begin
                pos_next  = ADDR_W'(end_pos - 1'b1);
                ram_raddr = ADDR_W'(end_pos - 1'b1);
            end
            ENG_AT_DATA: begin
                popped_next = ram_rdata;
                wr_ptr_next = pos_reg;
                ram_raddr   = ADDR_W'(pos_reg + 1'b1);
                if (pos_reg == top_addr) begin
                    entry_next              = entry_reg - 1'b1;
                    sub_next                = dec_sub;
                    fill_next               = dec_fill;
                    out_valid_next          = 1'b1;
                    out_next.popped         = ram_rdata;
                    out_next.status         = STS_OK;
                    out_next.item_count     = CNT_OUT_W'(entry_reg - 1'b1);
                    out_next.substack_count = CNT_OUT_W'(dec_sub);
                end
            end
            ENG_SHIFT: begin
                ram_we      = 1'b1;
                ram_waddr   = wr_ptr_reg;
                ram_wdata   = ram_rdata;
                ram_raddr   = ADDR_W'(wr_ptr_reg + 2'd2);
                wr_ptr_next = ADDR_W'(wr_ptr_reg + 1'b1);
                if (ADDR_W'(wr_ptr_reg + 1'b1) == top_addr) begin
                    entry_next              = entry_reg - 1'b1;
                    sub_next                = dec_sub;
                    fill_next               = dec_fill;
                    out_valid_next          = 1'b1;
                    out_next.popped         = popped_reg;
                    out_next.status         = STS_OK;
                    out_next.item_count     = CNT_OUT_W'(entry_reg - 1'b1);
                    out_next.substack_count = CNT_OUT_W'(dec_sub);
                end
            end
            ENG_DIV: begin
                dvd_next = {dvd_reg[CNT_W-2:0], qbit};
                rem_next = rem_step;
                dc_next  = dc_reg - 1'b1;
                if (dc_reg == '0) begin
                    sub_next  = {dvd_reg[CNT_W-2:0], qbit} + 1'b1;
                    fill_next = rem_step + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ENG_IDLE;
            cap_reg       <= CAP_RESET;
            entry_reg     <= '0;
            sub_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            entry_reg     <= entry_next;
            sub_reg       <= sub_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        pos_reg    <= pos_next;
        wr_ptr_reg <= wr_ptr_next;
        popped_reg <= popped_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dc_reg     <= dc_next;
        out_reg    <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
